>>> rtl/frame_rms_agc_macros.svh
// assertion macros for the frame rms agc block
`ifndef FRAME_RMS_AGC_MACROS_SVH
`define FRAME_RMS_AGC_MACROS_SVH
`ifndef SYNTHESIS
`define AGC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AGC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AGC_ASSERT(label, clk, rst_n, prop, msg)
`define AGC_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/frm_agc_pkg.sv
// shared types and constants for the frame rms agc block
package frm_agc_pkg;
    localparam int FRAME_MAX = 64;
    localparam int STORE_AW  = 6;
    localparam int CNT_W     = 7;
    localparam int ENERGY_W  = 37;
    localparam logic [15:0] UNITY_GAIN    = 16'd4096;
    localparam logic [15:0] RMS_THRESHOLD = 16'd32;

    localparam logic [2:0] REG_TARGET  = 3'd0;
    localparam logic [2:0] REG_CEILING = 3'd1;
    localparam logic [2:0] REG_FLOOR   = 3'd2;
    localparam logic [2:0] REG_ATTACK  = 3'd3;
    localparam logic [2:0] REG_RELEASE = 3'd4;

    typedef struct packed {
        logic                bank;
        logic [CNT_W-1:0]    count;
        logic [ENERGY_W-1:0] energy;
        logic                speech;
    } t_frame_desc;

    typedef struct packed {
        logic [14:0] target_level;
        logic [15:0] gain_ceiling;
        logic [15:0] gain_floor;
        logic [15:0] attack_weight;
        logic [15:0] release_weight;
    } t_agc_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_SQRT,
        ST_DIV_GAIN,
        ST_PICK,
        ST_MUL,
        ST_UPD,
        ST_RD,
        ST_PROD,
        ST_OUT
    } t_back_state;
endpackage

>>> rtl/frame_rms_agc.sv
// input transfers are accepted back to back while one of two frame buffers is free
// a closed frame passes the back end in order: idle, 37-bit mean divide, 16-bit root,
// 37-bit gain divide, pick, weight multiply, update, when speech is flagged and the root
// exceeds the rms threshold; the unity path skips the gain divide and pick;
// each output transfer then passes the read, product and output states
// synchronous active-low reset: gain to unity, buffers empty, registers to defaults
module frame_rms_agc
    import frm_agc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    input  logic        s_axis_tuser,   // [0] speech_flag
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    output logic        m_axis_tlast,   // frame_end_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_agc_cfg          r_cfg;
    logic              cfg_wr;
    logic              gain_reset;
    logic [2:0]        reg_idx;
    t_frame_desc       push_desc;
    t_frame_desc       head;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;
    logic [STORE_AW:0] rd_addr;
    logic [15:0]       rd_data;

    // register file, word index from the address
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    // only a write to a known register snaps the gain back to unity
    assign gain_reset = cfg_wr && (reg_idx == REG_TARGET || reg_idx == REG_CEILING
                        || reg_idx == REG_FLOOR || reg_idx == REG_ATTACK
                        || reg_idx == REG_RELEASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_level   <= 15'd3277;
            r_cfg.gain_ceiling   <= 16'd40960;
            r_cfg.gain_floor     <= 16'd410;
            r_cfg.attack_weight  <= 16'd6554;
            r_cfg.release_weight <= 16'd655;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TARGET:  r_cfg.target_level   <= pwdata[14:0];
                REG_CEILING: r_cfg.gain_ceiling   <= pwdata[15:0];
                REG_FLOOR:   r_cfg.gain_floor     <= pwdata[15:0];
                REG_ATTACK:  r_cfg.attack_weight  <= pwdata[15:0];
                REG_RELEASE: r_cfg.release_weight <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TARGET:  prdata = {17'd0, r_cfg.target_level};
            REG_CEILING: prdata = {16'd0, r_cfg.gain_ceiling};
            REG_FLOOR:   prdata = {16'd0, r_cfg.gain_floor};
            REG_ATTACK:  prdata = {16'd0, r_cfg.attack_weight};
            REG_RELEASE: prdata = {16'd0, r_cfg.release_weight};
            default:     prdata = 32'd0;
        endcase
    end

    // front end fills one buffer bank while the back end drains the other
    frm_agc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_full    (full),
        .i_sample  (s_axis_tdata),
        .i_speech  (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_desc    (push_desc)
    );

    // one entry per closed frame; an entry stays until its last sample is loaded for output
    frm_agc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (empty),
        .o_full      (full)
    );

    frm_agc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_gain_reset (gain_reset),
        .i_empty      (empty),
        .i_head       (head),
        .i_rd_data    (rd_data),
        .i_out_ready  (m_axis_tready),
        .o_rd_addr    (rd_addr),
        .o_pop        (pop),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );
endmodule

>>> rtl/frm_agc_fifo.sv
// two-entry queue of closed frame descriptors
module frm_agc_fifo
    import frm_agc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_push_desc,
    input  logic        i_pop,
    output t_frame_desc o_head,
    output logic        o_empty,
    output logic        o_full
);
`include "frame_rms_agc_macros.svh"

    t_frame_desc r_ent [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_head  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_push_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    `AGC_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `AGC_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `AGC_ASSERT(a_push_fills, i_clk, i_rst_n, (i_push && !i_pop) |=> !o_empty, "queue lost entry")
    `AGC_ASSERT(a_ptr_count, i_clk, i_rst_n, (r_cnt == 2'd1) |-> (r_wp != r_rp), "pointer mismatch")
endmodule

>>> rtl/frm_agc_front.sv
// input side: sample store, energy sum and frame closing
module frm_agc_front
    import frm_agc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_full,
    input  logic [15:0]           i_sample,
    input  logic                  i_speech,
    input  logic                  i_last,
    input  logic [STORE_AW:0]     i_rd_addr,
    output logic [15:0]           o_rd_data,
    output logic                  o_ready,
    output logic                  o_push,
    output t_frame_desc           o_desc
);
    logic [15:0]         r_mem [2*FRAME_MAX];
    logic                r_bank;
    logic [CNT_W-1:0]    r_fill;
    logic [ENERGY_W-1:0] r_energy;
    logic [CNT_W-1:0]    n_fill;
    logic [ENERGY_W-1:0] n_energy;
    logic signed [31:0]  sq;
    logic                accept;
    logic                close;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign sq       = $signed(i_sample) * $signed(i_sample);
    assign n_fill   = r_fill + CNT_W'(1);
    assign n_energy = r_energy + {{(ENERGY_W-32){1'b0}}, sq};
    assign close    = i_last || (n_fill == CNT_W'(FRAME_MAX));
    assign o_push   = accept && close;

    always_comb begin
        o_desc.bank   = r_bank;
        o_desc.count  = n_fill;
        o_desc.energy = n_energy;
        o_desc.speech = i_speech;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[{r_bank, r_fill[STORE_AW-1:0]}] <= i_sample;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= 1'b0;
            r_fill   <= '0;
            r_energy <= '0;
        end else if (accept) begin
            if (close) begin
                r_bank   <= ~r_bank;
                r_fill   <= '0;
                r_energy <= '0;
            end else begin
                r_fill   <= n_fill;
                r_energy <= n_energy;
            end
        end
    end
endmodule

>>> rtl/frm_agc_back.sv
// frame side: mean, root, gain divide, smoothing and sample scaling
module frm_agc_back
    import frm_agc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_agc_cfg          i_cfg,
    input  logic              i_gain_reset,
    input  logic              i_empty,
    input  t_frame_desc       i_head,
    input  logic [15:0]       i_rd_data,
    input  logic              i_out_ready,
    output logic [STORE_AW:0] o_rd_addr,
    output logic              o_pop,
    output logic              o_out_valid,
    output logic [15:0]       o_out_data,
    output logic              o_out_last
);
    t_back_state          r_state;
    t_back_state          n_state;
    logic [ENERGY_W-1:0]  r_acc;
    logic [15:0]          r_rem;
    logic [15:0]          r_dvs;
    logic [17:0]          r_srem;
    logic [15:0]          r_root;
    logic [5:0]           r_cnt;
    logic [15:0]          r_goal;
    logic [15:0]          r_wt;
    logic                 r_up;
    logic [31:0]          r_prod;
    logic [15:0]          r_gain;
    logic [STORE_AW-1:0]  r_idx;
    logic                 r_neg;

    logic [16:0]          rem_sh;
    logic                 div_ge;
    logic [15:0]          rem_n;
    logic [ENERGY_W-1:0]  acc_div;
    logic [19:0]          srem_sh;
    logic [19:0]          trial;
    logic                 sq_ge;
    logic [17:0]          srem_n;
    logic [15:0]          root_n;
    logic                 use_goal;
    logic [15:0]          d_ceil;
    logic [15:0]          d_clamp;
    logic [15:0]          diff;
    logic [15:0]          s_mag;
    logic [32:0]          rnd;
    logic [20:0]          p;
    logic [15:0]          scaled;
    logic                 last_item;
    logic                 out_free;

    // shared restoring divider step
    assign rem_sh  = {r_rem, r_acc[ENERGY_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_dvs};
    assign rem_n   = div_ge ? 16'(rem_sh - {1'b0, r_dvs}) : rem_sh[15:0];
    assign acc_div = {r_acc[ENERGY_W-2:0], div_ge};

    // digit-by-digit square root step, two radicand bits per cycle
    assign srem_sh = {r_srem, r_acc[31:30]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign sq_ge   = srem_sh >= trial;
    assign srem_n  = sq_ge ? 18'(srem_sh - trial) : srem_sh[17:0];
    assign root_n  = {r_root[14:0], sq_ge};
    assign use_goal = i_head.speech && (root_n > RMS_THRESHOLD);

    assign d_ceil  = (r_acc > {{(ENERGY_W-16){1'b0}}, i_cfg.gain_ceiling})
                     ? i_cfg.gain_ceiling : r_acc[15:0];
    assign d_clamp = (d_ceil < i_cfg.gain_floor) ? i_cfg.gain_floor : d_ceil;
    assign diff    = r_up ? (r_goal - r_gain) : (r_gain - r_goal);

    assign s_mag   = i_rd_data[15] ? (~i_rd_data + 16'd1) : i_rd_data;
    assign rnd     = {1'b0, r_prod} + 33'd2048;
    assign p       = rnd[32:12];
    always_comb begin
        if (r_neg) begin
            scaled = (p > 21'd32768) ? 16'h8000 : (~p[15:0] + 16'd1);
        end else begin
            scaled = (p > 21'd32767) ? 16'h7fff : p[15:0];
        end
    end

    assign last_item = ({1'b0, r_idx} + CNT_W'(1)) == i_head.count;
    assign out_free  = !o_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (!i_empty) n_state = ST_DIV_MEAN;
            ST_DIV_MEAN: if (r_cnt == 6'd0) n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_cnt == 6'd0) n_state = use_goal ? ST_DIV_GAIN : ST_MUL;
            end
            ST_DIV_GAIN: if (r_cnt == 6'd0) n_state = ST_PICK;
            ST_PICK:     n_state = ST_MUL;
            ST_MUL:      n_state = ST_UPD;
            ST_UPD:      n_state = ST_RD;
            ST_RD:       n_state = ST_PROD;
            ST_PROD:     n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) n_state = last_item ? ST_IDLE : ST_RD;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_rd_addr = {i_head.bank, r_idx};
        o_pop     = (r_state == ST_OUT) && out_free && last_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_acc <= i_head.energy;
                r_dvs <= {{(16-CNT_W){1'b0}}, i_head.count};
                r_rem <= '0;
                r_cnt <= 6'(ENERGY_W - 1);
            end
            ST_DIV_MEAN: begin
                r_acc <= acc_div;
                r_rem <= rem_n;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= 6'd15;
                end
            end
            ST_SQRT: begin
                r_acc  <= {r_acc[ENERGY_W-3:0], 2'b00};
                r_srem <= srem_n;
                r_root <= root_n;
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_acc  <= {10'd0, i_cfg.target_level, 12'd0};
                    r_dvs  <= root_n;
                    r_rem  <= '0;
                    r_cnt  <= 6'(ENERGY_W - 1);
                    r_goal <= UNITY_GAIN;
                    r_wt   <= i_cfg.release_weight;
                    r_up   <= UNITY_GAIN >= r_gain;
                end
            end
            ST_DIV_GAIN: begin
                r_acc <= acc_div;
                r_rem <= rem_n;
                r_cnt <= r_cnt - 6'd1;
            end
            ST_PICK: begin
                r_goal <= d_clamp;
                r_wt   <= (d_clamp < r_gain) ? i_cfg.attack_weight : i_cfg.release_weight;
                r_up   <= d_clamp >= r_gain;
            end
            ST_MUL: begin
                r_prod <= r_wt * diff;
            end
            ST_PROD: begin
                r_prod <= s_mag * r_gain;
                r_neg  <= i_rd_data[15];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= UNITY_GAIN;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_gain_reset) begin
                r_gain <= UNITY_GAIN;
            end else if (r_state == ST_UPD) begin
                r_gain <= r_up ? (r_gain + r_prod[31:16]) : (r_gain - r_prod[31:16]);
            end
            if (r_state == ST_UPD) begin
                r_idx <= '0;
            end else if (r_state == ST_OUT && out_free && !last_item) begin
                r_idx <= r_idx + STORE_AW'(1);
            end
            if (r_state == ST_OUT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            o_out_data <= scaled;
            o_out_last <= last_item;
        end
    end
endmodule
